// ===== rtl/run_limited_binary_count_assert.svh =====
// Assertion macros for the run-limited binary count block.
// Both expect a clock named clock and a synchronous active-high reset named reset.
`ifndef RUN_LIMITED_BINARY_COUNT_ASSERT_SVH
`define RUN_LIMITED_BINARY_COUNT_ASSERT_SVH

// Same-cycle implication.
`define RLBC_HOLDS(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("run-limited count: same-cycle check failed");

// Next-cycle implication.
`define RLBC_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("run-limited count: next-cycle check failed");

`endif

// ===== rtl/rlbc_pkg.sv =====
package rlbc_pkg;

   localparam int VAL_W         = 30;
   localparam int IN_W          = 8;
   localparam int DEF_MAX_COUNT = 255;

   typedef logic [VAL_W-1:0] val_type;

   localparam val_type SEQ_MOD = 30'd1000000007;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ_UP,
      ST_MERGE,
      ST_UPDATE,
      ST_TOTAL,
      ST_FINISH
   } rlbc_state_type;

   // (a + b) mod SEQ_MOD, both operands already reduced
   function automatic val_type add_mod(input val_type a, input val_type b);
      logic [VAL_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, SEQ_MOD}) begin
         return val_type'(s - {1'b0, SEQ_MOD});
      end
      return val_type'(s);
   endfunction

   // (a - b) mod SEQ_MOD, both operands already reduced
   function automatic val_type sub_mod(input val_type a, input val_type b);
      logic [VAL_W:0] t;
      t = {1'b0, a} + {1'b0, SEQ_MOD} - {1'b0, b};
      if (a >= b) begin
         return a - b;
      end
      return val_type'(t);
   endfunction

endpackage

// ===== rtl/run_limited_binary_count.sv =====
// Channel   | Direction | Ports                                           | Moves a word when
// ----------+-----------+-------------------------------------------------+--------------------
// request   | in        | req_valid, req_stall, req_zero_count,           | valid & !stall
//           |           | req_one_count, req_run_limit                    |
// response  | out       | rsp_valid, rsp_stall, rsp_sequence_count        | valid & !stall
//
// Sequence: with Z zeros and O ones (both non-zero) a request runs ST_READ_UP, then ST_MERGE
//   and ST_UPDATE for each of the Z*O cells, then ST_TOTAL and ST_FINISH; with either count
//   zero it goes straight to ST_FINISH. Each cell uses two states, as every table has one read
//   port and a cell needs two reads from each (the cell above and the cell one run-length back).
// Reset clears the sequencer and the response valid only; table contents are never cleared.
// A stalled response word is held while the next request is accepted and computed; the block
//   waits at the end of a request only if that word is still unclaimed.
`include "run_limited_binary_count_assert.svh"

module run_limited_binary_count #(
   parameter int MAX_COUNT = rlbc_pkg::DEF_MAX_COUNT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [rlbc_pkg::IN_W-1:0]  req_zero_count,
   input  logic [rlbc_pkg::IN_W-1:0]  req_one_count,
   input  logic [rlbc_pkg::IN_W-1:0]  req_run_limit,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [rlbc_pkg::VAL_W-1:0] rsp_sequence_count
);

   // Table geometry: row index is zeros used, column index is ones used.
   localparam int STRIDE = MAX_COUNT + 1;
   localparam int DEPTH  = STRIDE * STRIDE;
   localparam int AW     = $clog2(DEPTH);
   localparam int CW     = $clog2(STRIDE);
   localparam logic [AW-1:0] STRIDE_A = AW'(STRIDE);

   typedef logic [CW-1:0] idx_type;
   typedef logic [AW-1:0] addr_type;

   function automatic addr_type cell_addr(input idx_type r, input idx_type c);
      return AW'(r) * STRIDE_A + AW'(c);
   endfunction

   // Sequencer and datapath registers.
   rlbc_pkg::rlbc_state_type state_ff, state_in;

   idx_type                 z_ff, z_in;
   idx_type                 o_ff, o_in;
   logic [rlbc_pkg::IN_W-1:0] lim_ff, lim_in;
   idx_type                 i_ff, i_in;
   idx_type                 j_ff, j_in;

   rlbc_pkg::val_type sum_zero_ff, sum_zero_in;
   rlbc_pkg::val_type sum_one_ff, sum_one_in;
   rlbc_pkg::val_type prev_zero_ff, prev_zero_in;
   rlbc_pkg::val_type prev_one_ff, prev_one_in;
   rlbc_pkg::val_type result_ff, result_in;

   // Read overrides: a base-case value or a forwarded write replaces the memory word.
   logic              zero_ovr_ff, zero_ovr_in;
   rlbc_pkg::val_type zero_ovr_val_ff, zero_ovr_val_in;
   logic              one_ovr_ff, one_ovr_in;
   rlbc_pkg::val_type one_ovr_val_ff, one_ovr_val_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rlbc_pkg::val_type rsp_count_ff, rsp_count_in;

   // Tables of sequences ending in zero and ending in one.
   rlbc_pkg::val_type zero_mem [DEPTH];
   rlbc_pkg::val_type one_mem [DEPTH];
   rlbc_pkg::val_type zero_rd_ff;
   rlbc_pkg::val_type one_rd_ff;

   addr_type          zero_raddr;
   addr_type          one_raddr;
   addr_type          waddr;
   logic              wr_en;
   rlbc_pkg::val_type wr_zero;
   rlbc_pkg::val_type wr_one;

   // Combinational helpers.
   idx_type                 zs, os, n_short, ni, nj, far_row, far_col;
   logic [rlbc_pkg::IN_W:0] lim_p1;
   rlbc_pkg::val_type       zero_op, one_op, new_zero, new_one;
   logic                    row_end, last, out_free;

   // Checker terms.
   logic                    on_cell, cell_ok, wide_row_turn;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         zero_mem[waddr] <= wr_zero;
      end
      zero_rd_ff <= zero_mem[zero_raddr];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         one_mem[waddr] <= wr_one;
      end
      one_rd_ff <= one_mem[one_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rlbc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      z_ff            <= z_in;
      o_ff            <= o_in;
      lim_ff          <= lim_in;
      i_ff            <= i_in;
      j_ff            <= j_in;
      sum_zero_ff     <= sum_zero_in;
      sum_one_ff      <= sum_one_in;
      prev_zero_ff    <= prev_zero_in;
      prev_one_ff     <= prev_one_in;
      result_ff       <= result_in;
      zero_ovr_ff     <= zero_ovr_in;
      zero_ovr_val_ff <= zero_ovr_val_in;
      one_ovr_ff      <= one_ovr_in;
      one_ovr_val_ff  <= one_ovr_val_in;
      rsp_count_ff    <= rsp_count_in;
   end

   always_comb begin
      // Saturate the counts to the table size.
      zs = (req_zero_count > MAX_COUNT) ? CW'(MAX_COUNT) : CW'(req_zero_count);
      os = (req_one_count > MAX_COUNT) ? CW'(MAX_COUNT) : CW'(req_one_count);
      // With one count zero the answer is 1 exactly when the other count is non-zero and fits one run.
      n_short = (zs == '0) ? os : zs;

      lim_p1  = {1'b0, lim_ff} + 9'd1;
      zero_op = zero_ovr_ff ? zero_ovr_val_ff : zero_rd_ff;
      one_op  = one_ovr_ff ? one_ovr_val_ff : one_rd_ff;

      // Drop the term whose final run would run past the limit.
      new_zero = (i_ff > lim_ff) ? rlbc_pkg::sub_mod(sum_zero_ff, one_op) : sum_zero_ff;
      new_one  = (j_ff > lim_ff) ? rlbc_pkg::sub_mod(sum_one_ff, zero_op) : sum_one_ff;

      row_end = (j_ff == o_ff);
      last    = row_end && (i_ff == z_ff);
      ni      = row_end ? CW'(i_ff + 1'b1) : i_ff;
      nj      = row_end ? CW'(1) : CW'(j_ff + 1'b1);
      far_row = (i_ff > lim_ff) ? CW'(i_ff - lim_p1) : i_ff;
      far_col = (j_ff > lim_ff) ? CW'(j_ff - lim_p1) : j_ff;

      out_free = !rsp_valid_ff || !rsp_stall;

      state_in        = state_ff;
      z_in            = z_ff;
      o_in            = o_ff;
      lim_in          = lim_ff;
      i_in            = i_ff;
      j_in            = j_ff;
      sum_zero_in     = sum_zero_ff;
      sum_one_in      = sum_one_ff;
      prev_zero_in    = prev_zero_ff;
      prev_one_in     = prev_one_ff;
      result_in       = result_ff;
      zero_ovr_in     = zero_ovr_ff;
      zero_ovr_val_in = zero_ovr_val_ff;
      one_ovr_in      = one_ovr_ff;
      one_ovr_val_in  = one_ovr_val_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_count_in    = rsp_count_ff;

      zero_raddr = cell_addr(i_ff, j_ff);
      one_raddr  = cell_addr(i_ff, j_ff);
      waddr      = cell_addr(i_ff, j_ff);
      wr_en      = 1'b0;
      wr_zero    = new_zero;
      wr_one     = new_one;

      req_stall = (state_ff != rlbc_pkg::ST_IDLE);

      unique case (state_ff)
         rlbc_pkg::ST_IDLE: begin
            if (req_valid) begin
               z_in   = zs;
               o_in   = os;
               lim_in = req_run_limit;
               i_in   = CW'(1);
               j_in   = CW'(1);
               // Column 0 of row 1: a single zero fits any non-zero limit.
               prev_zero_in = rlbc_pkg::val_type'(req_run_limit != '0);
               prev_one_in  = '0;
               if ((zs == '0) || (os == '0)) begin
                  result_in = rlbc_pkg::val_type'((n_short != '0) && (n_short <= req_run_limit));
                  state_in  = rlbc_pkg::ST_FINISH;
               end else begin
                  state_in = rlbc_pkg::ST_READ_UP;
               end
            end
         end

         rlbc_pkg::ST_READ_UP: begin
            // Cell (1,1): both upper neighbours lie in row 0, taken as base values.
            zero_ovr_in     = 1'b1;
            zero_ovr_val_in = '0;
            one_ovr_in      = 1'b1;
            one_ovr_val_in  = rlbc_pkg::val_type'(lim_ff != '0);
            state_in        = rlbc_pkg::ST_MERGE;
         end

         rlbc_pkg::ST_MERGE: begin
            // Upper neighbours have arrived; the left neighbour sits in prev registers.
            sum_zero_in = rlbc_pkg::add_mod(zero_op, one_op);
            sum_one_in  = rlbc_pkg::add_mod(prev_zero_ff, prev_one_ff);
            // Fetch the run-length terms; row 0 and column 0 come from base values.
            zero_raddr      = cell_addr(i_ff, far_col);
            one_raddr       = cell_addr(far_row, j_ff);
            zero_ovr_in     = (j_ff == lim_p1);
            zero_ovr_val_in = rlbc_pkg::val_type'(i_ff <= lim_ff);
            one_ovr_in      = (i_ff == lim_p1);
            one_ovr_val_in  = rlbc_pkg::val_type'(j_ff <= lim_ff);
            state_in        = rlbc_pkg::ST_UPDATE;
         end

         rlbc_pkg::ST_UPDATE: begin
            wr_en = 1'b1;
            i_in  = ni;
            j_in  = nj;
            if (last) begin
               prev_zero_in = new_zero;
               prev_one_in  = new_one;
               state_in     = rlbc_pkg::ST_TOTAL;
            end else begin
               if (row_end) begin
                  // Start the next row from its column 0 entry.
                  prev_zero_in = rlbc_pkg::val_type'(i_ff < lim_ff);
                  prev_one_in  = '0;
               end else begin
                  prev_zero_in = new_zero;
                  prev_one_in  = new_one;
               end
               zero_raddr = cell_addr(CW'(ni - 1'b1), nj);
               one_raddr  = cell_addr(CW'(ni - 1'b1), nj);
               if (ni == CW'(1)) begin
                  zero_ovr_in     = 1'b1;
                  zero_ovr_val_in = '0;
                  one_ovr_in      = 1'b1;
                  one_ovr_val_in  = rlbc_pkg::val_type'(nj <= lim_ff);
               end else if (row_end && (o_ff == CW'(1))) begin
                  // Single-column table: the cell above is the one written now, so forward it.
                  zero_ovr_in     = 1'b1;
                  zero_ovr_val_in = new_zero;
                  one_ovr_in      = 1'b1;
                  one_ovr_val_in  = new_one;
               end else begin
                  zero_ovr_in = 1'b0;
                  one_ovr_in  = 1'b0;
               end
               state_in = rlbc_pkg::ST_MERGE;
            end
         end

         rlbc_pkg::ST_TOTAL: begin
            result_in = rlbc_pkg::add_mod(prev_zero_ff, prev_one_ff);
            state_in  = rlbc_pkg::ST_FINISH;
         end

         rlbc_pkg::ST_FINISH: begin
            // Hold the answer until the response register is free.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = result_ff;
               state_in     = rlbc_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = rlbc_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sequence_count = rsp_count_ff;

   assign on_cell       = (state_ff == rlbc_pkg::ST_MERGE) || (state_ff == rlbc_pkg::ST_UPDATE);
   assign cell_ok       = (i_ff != '0) && (i_ff <= z_ff) && (j_ff != '0) && (j_ff <= o_ff);
   assign wide_row_turn = (state_ff == rlbc_pkg::ST_UPDATE) && !last && row_end
                          && (o_ff != CW'(1));

   `RLBC_HOLDS(a_cell_in_range, on_cell, cell_ok)
   `RLBC_NEXT(a_merge_then_update, state_ff == rlbc_pkg::ST_MERGE, state_ff == rlbc_pkg::ST_UPDATE)
   `RLBC_NEXT(a_no_forward_wide, wide_row_turn, !zero_ovr_ff && !one_ovr_ff)
   `RLBC_HOLDS(a_result_reduced, rsp_valid_ff, rsp_count_ff < rlbc_pkg::SEQ_MOD)

endmodule
